FILE: hdl/boxavg_pkg.sv
// boxavg_pkg: shared constants, register codes and the queue item type
// of the box average downsampler. No dependencies.
`timescale 1ns / 1ps

package boxavg_pkg;

   // default sizes, handed to the top level parameters
   localparam int DEF_MAX_OUT_WIDTH = 256;
   localparam int DEF_MAX_FACTOR    = 16;

   // fixed field widths
   localparam int SAMPLE_W         = 16;
   localparam int ROW_W            = 8;
   localparam int COL_OUT_W        = 8;
   localparam int FACTOR_REG_W     = 5;
   localparam int HEIGHT_W         = 9;
   localparam int OUT_HEIGHT_LIMIT = 256;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_Y   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_X   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 4'd3;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // classified pixel, front to back (column travels beside it)
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [ROW_W-1:0]           row;
      logic                       first;
      logic                       tile_end;
      logic                       frame_last;
   } item_type;

endpackage

FILE: hdl/boxavg_ram.sv
// boxavg_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module boxavg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/boxavg_fifo.sv
// boxavg_fifo: small first-in first-out queue between the front and the
// back of the downsampler. No dependencies.
`timescale 1ns / 1ps

module boxavg_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_fill_tracks_push : assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue fill count missed a push");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");
`endif

endmodule

FILE: hdl/boxavg_front.sv
// boxavg_front: configuration registers and raster counters; classifies
// each pixel by column, row and tile position. Depends on boxavg_pkg.
`timescale 1ns / 1ps

module boxavg_front
   import boxavg_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int MAX_FACTOR    = DEF_MAX_FACTOR,
   localparam int FW  = $clog2(MAX_FACTOR + 1),
   localparam int SCW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1,
   localparam int WW  = $clog2(MAX_OUT_WIDTH + 1),
   localparam int CW  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
   localparam int AW  = 2 * FW
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       push_valid,
   output item_type                   push_item,
   output logic [CW-1:0]              push_col,
   input  logic                       queue_full,
   output logic [AW-1:0]              area
);

   logic [FW-1:0]       fy_ff, fy_in;
   logic [FW-1:0]       fx_ff, fx_in;
   logic [WW-1:0]       w_ff, w_in;
   logic [HEIGHT_W-1:0] h_ff, h_in;
   logic [AW-1:0]       area_ff;

   logic [SCW-1:0]   sub_col_ff, sub_col_in;
   logic [SCW-1:0]   sub_row_ff, sub_row_in;
   logic [CW-1:0]    block_col_ff, block_col_in;
   logic [ROW_W-1:0] block_row_ff, block_row_in;

   logic cfg_hit;
   logic accept;
   logic sub_col_end, col_end, sub_row_end, row_end;

   function automatic logic [FW-1:0] clamp_factor(input logic [FACTOR_REG_W-1:0] v);
      logic [FW-1:0] r;
      if (v == '0) begin
         r = FW'(1);
      end else if (int'(v) > MAX_FACTOR) begin
         r = FW'(MAX_FACTOR);
      end else begin
         r = FW'(v);
      end
      return r;
   endfunction

   function automatic logic [WW-1:0] clamp_width(input logic [CSR_DATA_W-1:0] v);
      logic [WW-1:0] r;
      if (v == '0) begin
         r = WW'(1);
      end else if (int'(v) > MAX_OUT_WIDTH) begin
         r = WW'(MAX_OUT_WIDTH);
      end else begin
         r = WW'(v);
      end
      return r;
   endfunction

   function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CSR_DATA_W-1:0] v);
      logic [HEIGHT_W-1:0] r;
      if (v == '0) begin
         r = HEIGHT_W'(1);
      end else if (int'(v) > OUT_HEIGHT_LIMIT) begin
         r = HEIGHT_W'(OUT_HEIGHT_LIMIT);
      end else begin
         r = HEIGHT_W'(v);
      end
      return r;
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign area       = area_ff;

   // register writes; only known indexes restart the frame
   always_comb begin
      fy_in   = fy_ff;
      fx_in   = fx_ff;
      w_in    = w_ff;
      h_in    = h_ff;
      cfg_hit = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FACTOR_Y: begin
               fy_in   = clamp_factor(csr_data[FACTOR_REG_W-1:0]);
               cfg_hit = 1'b1;
            end
            REG_FACTOR_X: begin
               fx_in   = clamp_factor(csr_data[FACTOR_REG_W-1:0]);
               cfg_hit = 1'b1;
            end
            REG_OUT_WIDTH: begin
               w_in    = clamp_width(csr_data);
               cfg_hit = 1'b1;
            end
            REG_OUT_HEIGHT: begin
               h_in    = clamp_height(csr_data);
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   // tile and frame position of the current pixel
   assign sub_col_end = (FW'(sub_col_ff) + FW'(1)) >= fx_ff;
   assign sub_row_end = (FW'(sub_row_ff) + FW'(1)) >= fy_ff;
   assign col_end     = (WW'(block_col_ff) + WW'(1)) >= w_ff;
   assign row_end     = (HEIGHT_W'(block_row_ff) + HEIGHT_W'(1)) >= h_ff;

   always_comb begin
      sub_col_in   = sub_col_ff;
      sub_row_in   = sub_row_ff;
      block_col_in = block_col_ff;
      block_row_in = block_row_ff;
      if (cfg_hit) begin
         sub_col_in   = '0;
         sub_row_in   = '0;
         block_col_in = '0;
         block_row_in = '0;
      end else if (accept) begin
         if (!sub_col_end) begin
            sub_col_in = sub_col_ff + SCW'(1);
         end else begin
            sub_col_in = '0;
            if (!col_end) begin
               block_col_in = block_col_ff + CW'(1);
            end else begin
               block_col_in = '0;
               if (!sub_row_end) begin
                  sub_row_in = sub_row_ff + SCW'(1);
               end else begin
                  sub_row_in   = '0;
                  block_row_in = row_end ? '0 : block_row_ff + ROW_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fy_ff        <= FW'(1);
         fx_ff        <= FW'(1);
         w_ff         <= WW'(1);
         h_ff         <= HEIGHT_W'(1);
         area_ff      <= AW'(1);
         sub_col_ff   <= '0;
         sub_row_ff   <= '0;
         block_col_ff <= '0;
         block_row_ff <= '0;
      end else begin
         fy_ff        <= fy_in;
         fx_ff        <= fx_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         area_ff      <= AW'(fy_ff) * AW'(fx_ff);
         sub_col_ff   <= sub_col_in;
         sub_row_ff   <= sub_row_in;
         block_col_ff <= block_col_in;
         block_row_ff <= block_row_in;
      end
   end

   always_comb begin
      push_valid           = accept;
      push_item.sample     = req_sample;
      push_item.row        = block_row_ff;
      push_item.first      = (sub_row_ff == '0) && (sub_col_ff == '0);
      push_item.tile_end   = sub_row_end && sub_col_end;
      push_item.frame_last = row_end && col_end;
      push_col             = block_col_ff;
   end

`ifndef ASSERT_OFF
   a_restart : assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (sub_col_ff == '0 && sub_row_ff == '0 &&
                   block_col_ff == '0 && block_row_ff == '0))
      else $error("register write did not restart the frame");

   a_in_bounds : assert property (@(posedge clock) disable iff (reset)
      (FW'(sub_col_ff) < fx_ff) && (FW'(sub_row_ff) < fy_ff) &&
      (WW'(block_col_ff) < w_ff) && (HEIGHT_W'(block_row_ff) < h_ff))
      else $error("raster counter left the configured frame");
`endif

endmodule

FILE: hdl/boxavg_back.sv
// boxavg_back: column sum update with forwarding, pipelined restoring
// divider and output register. Depends on boxavg_pkg and boxavg_ram.
`timescale 1ns / 1ps

module boxavg_back
   import boxavg_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int MAX_FACTOR    = DEF_MAX_FACTOR,
   localparam int FW    = $clog2(MAX_FACTOR + 1),
   localparam int CW    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
   localparam int AW    = 2 * FW,
   localparam int SUM_W = SAMPLE_W + ((MAX_FACTOR > 1) ? 2 * $clog2(MAX_FACTOR) : 0)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_valid,
   output logic                       queue_pop,
   input  item_type                   queue_item,
   input  logic [CW-1:0]              queue_col,
   input  logic [AW-1:0]              area,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic [ROW_W-1:0]           rsp_row,
   output logic [COL_OUT_W-1:0]       rsp_col,
   output logic                       rsp_last
);

   logic adv;

   // sum stage
   logic                    s1_valid_ff;
   item_type                s1_item_ff;
   logic [CW-1:0]           s1_col_ff;
   logic [SUM_W-1:0]        ram_rd_data;
   logic signed [SUM_W-1:0] base_sum;
   logic signed [SUM_W-1:0] sample_ext;
   logic signed [SUM_W-1:0] new_sum;
   logic                    wr_en;

   // newest write, forwarded on a column match
   logic                    lw_valid_ff;
   logic [CW-1:0]           lw_col_ff;
   logic signed [SUM_W-1:0] lw_sum_ff;

   // finished tile sum
   logic                    s2_valid_ff;
   logic signed [SUM_W-1:0] s2_sum_ff;
   logic [ROW_W-1:0]        s2_row_ff;
   logic [CW-1:0]           s2_col_ff;
   logic                    s2_last_ff;

   // divider stages, index 0 holds the magnitude
   logic             dv_valid_ff [0:SUM_W];
   logic             dv_neg_ff   [0:SUM_W];
   logic [SUM_W-1:0] dv_q_ff     [0:SUM_W];
   logic [AW-1:0]    dv_r_ff     [0:SUM_W];
   logic [ROW_W-1:0] dv_row_ff   [0:SUM_W];
   logic [CW-1:0]    dv_col_ff   [0:SUM_W];
   logic             dv_last_ff  [0:SUM_W];

   // output register
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_avg_ff;
   logic [ROW_W-1:0]           out_row_ff;
   logic [CW-1:0]              out_col_ff;
   logic                       out_last_ff;

   // whole back end moves together when the output can take a beat
   assign adv       = !out_valid_ff || rsp_tready;
   assign queue_pop = adv && queue_valid;
   assign wr_en     = adv && s1_valid_ff;

   boxavg_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (new_sum),
      .rd_en   (queue_pop),
      .rd_addr (queue_col),
      .rd_data (ram_rd_data)
   );

   assign sample_ext = SUM_W'(s1_item_ff.sample);
   assign base_sum   = (lw_valid_ff && lw_col_ff == s1_col_ff) ? lw_sum_ff
                                                              : $signed(ram_rd_data);
   assign new_sum    = s1_item_ff.first ? sample_ext : base_sum + sample_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= queue_valid;
         s2_valid_ff    <= s1_valid_ff && s1_item_ff.tile_end;
         dv_valid_ff[0] <= s2_valid_ff;
         out_valid_ff   <= dv_valid_ff[SUM_W];
         if (wr_en) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s1_item_ff <= queue_item;
         s1_col_ff  <= queue_col;
      end
      if (wr_en) begin
         lw_col_ff <= s1_col_ff;
         lw_sum_ff <= new_sum;
      end
      if (adv) begin
         s2_sum_ff      <= new_sum;
         s2_row_ff      <= s1_item_ff.row;
         s2_col_ff      <= s1_col_ff;
         s2_last_ff     <= s1_item_ff.frame_last;
         dv_neg_ff[0]   <= s2_sum_ff[SUM_W-1];
         dv_q_ff[0]     <= s2_sum_ff[SUM_W-1] ? -s2_sum_ff : s2_sum_ff;
         dv_r_ff[0]     <= '0;
         dv_row_ff[0]   <= s2_row_ff;
         dv_col_ff[0]   <= s2_col_ff;
         dv_last_ff[0]  <= s2_last_ff;
         out_avg_ff     <= dv_neg_ff[SUM_W] ? SAMPLE_W'(-dv_q_ff[SUM_W])
                                           : SAMPLE_W'(dv_q_ff[SUM_W]);
         out_row_ff     <= dv_row_ff[SUM_W];
         out_col_ff     <= dv_col_ff[SUM_W];
         out_last_ff    <= dv_last_ff[SUM_W];
      end
   end

   // one quotient bit per stage, restoring long division by the tile area
   for (genvar k = 1; k <= SUM_W; k++) begin : g_div
      logic [AW:0] trial;
      logic [AW:0] diff;
      logic        ge;

      assign trial = {dv_r_ff[k-1], dv_q_ff[k-1][SUM_W-1]};
      assign ge    = trial >= {1'b0, area};
      assign diff  = trial - {1'b0, area};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_r_ff[k]    <= ge ? diff[AW-1:0] : trial[AW-1:0];
            dv_q_ff[k]    <= {dv_q_ff[k-1][SUM_W-2:0], ge};
            dv_neg_ff[k]  <= dv_neg_ff[k-1];
            dv_row_ff[k]  <= dv_row_ff[k-1];
            dv_col_ff[k]  <= dv_col_ff[k-1];
            dv_last_ff[k] <= dv_last_ff[k-1];
         end
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_average = out_avg_ff;
   assign rsp_row     = out_row_ff;
   assign rsp_col     = COL_OUT_W'(out_col_ff);
   assign rsp_last    = out_last_ff;

`ifndef ASSERT_OFF
   a_stall_no_read : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> (!queue_pop && !wr_en))
      else $error("back end moved while the output was stalled");
`endif

endmodule

FILE: hdl/box_average_downsampler_top.sv
// box_average_downsampler_top: top level of the box average downsampler.
// Depends on boxavg_pkg, boxavg_front, boxavg_fifo and boxavg_back.
`timescale 1ns / 1ps

// Box-filter downsampler. Oversampled pixels arrive on the req_ stream in
// raster order, one 16-bit signed sample per beat; the image holds
// out_height*factor_y rows of out_width*factor_x pixels. Each tile is summed
// into a per-column line of partial sums, and on the tile's bottom-right
// pixel one rsp_ beat carries the tile average (sum / area, truncated toward
// zero) with its output row and column; rsp_tlast marks the frame's last
// tile. Other pixels produce no beat.
// Throughput: one pixel per clock while the back end is not frozen. A
// tile's result passes from the sum stage through the tile-sum register,
// the one-bit-per-stage pipelined divider and the output register.
// The csr_ port (always ready) writes factor_y, factor_x, out_width,
// out_height at indexes 0..3 and restarts the frame; write only when idle.
// Reset sets all four registers to 1, zeroes the raster counters and
// empties the pipeline; the column sums are not cleared, since a tile's
// first pixel overwrites its entry.
// When a result waits and rsp_tready is low, the back end freezes; a
// four-beat queue keeps taking pixels until it fills, then req_tready drops.

module box_average_downsampler_top
   import boxavg_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int MAX_FACTOR    = DEF_MAX_FACTOR
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // pixel stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sample
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [15:0] average, [23:16] out_row, [31:24] out_col
   output logic                  rsp_tlast    // frame_end
);

   localparam int FW = $clog2(MAX_FACTOR + 1);
   localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int AW = 2 * FW;
   localparam int QW = $bits(item_type) + CW;

   // front to queue
   logic          push_valid;
   item_type      push_item;
   logic [CW-1:0] push_col;
   logic          queue_full;
   logic [AW-1:0] area;

   // queue to back
   logic          queue_valid;
   logic          queue_pop;
   logic [QW-1:0] queue_data;
   item_type      queue_item;
   logic [CW-1:0] queue_col;

   // result fields before packing
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic [ROW_W-1:0]           rsp_row;
   logic [COL_OUT_W-1:0]       rsp_col;

   // counters, registers and pixel classification
   boxavg_front #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_FACTOR    (MAX_FACTOR)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata[SAMPLE_W-1:0]),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_col   (push_col),
      .queue_full (queue_full),
      .area       (area)
   );

   // decouples the pixel side from output stalls
   boxavg_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_item, push_col}),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .valid     (queue_valid)
   );

   assign queue_item = queue_data[QW-1:CW];
   assign queue_col  = queue_data[CW-1:0];

   // column sums, divider and output register
   boxavg_back #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_FACTOR    (MAX_FACTOR)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_pop   (queue_pop),
      .queue_item  (queue_item),
      .queue_col   (queue_col),
      .area        (area),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_average (rsp_average),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_last    (rsp_tlast)
   );

   // pack result fields, column highest, average lowest
   assign rsp_tdata = {rsp_col, rsp_row, rsp_average};

endmodule
